// ===== sv/priority_voice_block_mixer_core_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the priority voice block mixer
// Concurrent checks that compile away when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef PRIORITY_VOICE_BLOCK_MIXER_CORE_MACROS_SVH
`define PRIORITY_VOICE_BLOCK_MIXER_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define PVBM_ASSERT_NOW(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error(msg);
`define PVBM_ASSERT_NEXT(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);
`else
`define PVBM_ASSERT_NOW(label, clk, rst_n, cond, expr, msg)
`define PVBM_ASSERT_NEXT(label, clk, rst_n, cond, expr, msg)
`endif

`endif

// ===== sv/pvbm_pkg.sv =====
// ---------------------------------------------------------------------------
// Priority voice block mixer package
// Sizes, widths and function codes shared by the mixer core.
// ---------------------------------------------------------------------------
`default_nettype none

package pvbm_pkg;

    localparam int VOICES      = 4;
    localparam int BLOCK_BYTES = 256;
    localparam int LANES       = 4;
    localparam int MIX_LANES   = (VOICES < LANES) ? VOICES : LANES;

    localparam int FUNC_W     = 2;
    localparam int ADDR_W     = 24;
    localparam int END_W      = ADDR_W + 1;
    localparam int PRIO_W     = 8;
    localparam int WORD_W     = 32;
    localparam int VOICE_W    = 2;
    localparam int IDX_W      = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int LANE_IDX_W = $clog2(LANES);

    typedef enum logic [FUNC_W-1:0] {
        FUNC_PLAY = 2'd0,
        FUNC_FILL = 2'd1,
        FUNC_MIX  = 2'd2
    } t_func;

endpackage

`default_nettype wire

// ===== sv/priority_voice_block_mixer_core.sv =====
// ---------------------------------------------------------------------------
// Priority voice block mixer core
// Four sample voices with priority stealing, block fetch requests and a
// lane word mixer, run by a small sequencer around one shared adder.
// ---------------------------------------------------------------------------
// The input channel (i_valid, o_ready) carries one command per transaction:
// play places a sample in a voice, fill requests the next block of every
// active voice, and mix adds the lane words of the voices recorded at the
// last fill. The output channel (o_valid, i_ready) returns one result per
// transaction; play and mix give one, fill gives one per active voice (or a
// single clear-block result), and o_last marks the final one.
// Play scans the voices one per cycle. Fill passes over an idle voice in
// S_FILL and takes an active one through S_FILL and S_FILL_WRAP. Mix steps
// through the four lanes in S_MIX and then registers the sum in S_MIX_EMIT.
// All of these steps share the one 32-bit adder.
// o_ready is high only while the sequencer is idle. A result waiting in the
// output register does not block the next command, but when the receiver
// stalls the sequencer holds before loading its next result.
// Reset clears all voices, the mix record and the output register.
// ---------------------------------------------------------------------------
`default_nettype none
`include "priority_voice_block_mixer_core_macros.svh"

module priority_voice_block_mixer_core (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_ready,
    input  wire logic [pvbm_pkg::FUNC_W-1:0]  i_func,
    input  wire logic [pvbm_pkg::ADDR_W-1:0]  i_start_address,
    input  wire logic [pvbm_pkg::ADDR_W-1:0]  i_sample_length,
    input  wire logic [pvbm_pkg::ADDR_W-1:0]  i_loop_length,
    input  wire logic [pvbm_pkg::PRIO_W-1:0]  i_request_priority,
    input  wire logic [pvbm_pkg::WORD_W-1:0]  i_lane_word_0,
    input  wire logic [pvbm_pkg::WORD_W-1:0]  i_lane_word_1,
    input  wire logic [pvbm_pkg::WORD_W-1:0]  i_lane_word_2,
    input  wire logic [pvbm_pkg::WORD_W-1:0]  i_lane_word_3,
    output logic                              o_valid,
    input  wire logic                         i_ready,
    output logic [pvbm_pkg::VOICE_W-1:0]      o_voice,
    output logic                              o_valid_voice,
    output logic [pvbm_pkg::ADDR_W-1:0]       o_fetch_address,
    output logic                              o_copy_not_add,
    output logic                              o_last,
    output logic [pvbm_pkg::WORD_W-1:0]       o_mixed_word
);

    import pvbm_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PLAY,
        S_PLAY_WRITE,
        S_FILL,
        S_FILL_WRAP,
        S_CLEAR,
        S_MIX,
        S_MIX_EMIT
    } t_state;

    t_state              r_state;
    logic [IDX_W-1:0]    r_idx;

    logic [VOICES-1:0]   r_active;
    logic [ADDR_W-1:0]   r_pos   [VOICES];
    logic [END_W-1:0]    r_end   [VOICES];
    logic [ADDR_W-1:0]   r_loop  [VOICES];
    logic [PRIO_W-1:0]   r_vprio [VOICES];
    logic [VOICES-1:0]   r_mix_mask;

    logic [VOICES-1:0]   r_snap;
    logic                r_first;
    logic [ADDR_W-1:0]   r_start;
    logic [ADDR_W-1:0]   r_len;
    logic [ADDR_W-1:0]   r_req_loop;
    logic [PRIO_W-1:0]   r_req_prio;
    logic [IDX_W-1:0]    r_pick;
    logic                r_pick_valid;
    logic [PRIO_W-1:0]   r_best;
    logic [WORD_W-1:0]   r_lane [LANES];
    logic [WORD_W-1:0]   r_acc;

    logic                r_out_valid;
    logic [VOICE_W-1:0]  r_voice;
    logic                r_valid_voice;
    logic [ADDR_W-1:0]   r_fetch_address;
    logic                r_copy_not_add;
    logic                r_last;
    logic [WORD_W-1:0]   r_mixed_word;

    logic [WORD_W-1:0]   alu_a;
    logic [WORD_W-1:0]   alu_b;
    logic                alu_sub;
    logic [WORD_W-1:0]   alu_sum;

    logic                w_out_free;
    logic                w_load;
    logic                w_end_hit;
    logic                w_stop;
    logic [ADDR_W-1:0]   w_wrap_pos;
    logic [VOICES-1:0]   w_above;
    logic                w_more;
    logic                w_steal;
    logic                w_scan_done;
    logic                w_mix_done;

    assign o_ready         = (r_state == S_IDLE);
    assign o_valid         = r_out_valid;
    assign o_voice         = r_voice;
    assign o_valid_voice   = r_valid_voice;
    assign o_fetch_address = r_fetch_address;
    assign o_copy_not_add  = r_copy_not_add;
    assign o_last          = r_last;
    assign o_mixed_word    = r_mixed_word;

    assign w_out_free = !r_out_valid || i_ready;
    assign w_load     = w_out_free && ((r_state == S_PLAY_WRITE) || (r_state == S_FILL_WRAP) ||
                                       (r_state == S_CLEAR) || (r_state == S_MIX_EMIT));

    always_comb begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
        case (r_state)
            S_PLAY_WRITE: begin
                alu_a = WORD_W'(r_start);
                alu_b = WORD_W'(r_len);
            end
            S_FILL: begin
                alu_a = WORD_W'(r_pos[r_idx]);
                alu_b = WORD_W'(BLOCK_BYTES);
            end
            S_FILL_WRAP: begin
                alu_a   = r_acc;
                alu_b   = WORD_W'(r_loop[r_idx]);
                alu_sub = 1'b1;
            end
            S_MIX: begin
                alu_a = r_acc;
                alu_b = r_lane[LANE_IDX_W'(r_idx)];
            end
            default: begin
                alu_a = '0;
            end
        endcase
    end

    assign alu_sum = alu_a + (alu_sub ? ~alu_b : alu_b) + WORD_W'(alu_sub);

    assign w_end_hit  = (r_acc[END_W-1:0] >= r_end[r_idx]);
    assign w_stop     = w_end_hit && (r_loop[r_idx] == '0);
    assign w_wrap_pos = (w_end_hit && !w_stop) ? alu_sum[ADDR_W-1:0] : r_acc[ADDR_W-1:0];

    always_comb begin
        for (int j = 0; j < VOICES; j++) begin
            w_above[j] = (IDX_W'(j) > r_idx);
        end
    end

    assign w_more      = |(r_snap & w_above);
    assign w_steal     = (r_vprio[r_idx] > r_req_prio) && (r_vprio[r_idx] > r_best);
    assign w_scan_done = (r_idx == IDX_W'(VOICES - 1));
    assign w_mix_done  = (r_idx == IDX_W'(MIX_LANES - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_active    <= '0;
            r_mix_mask  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_ready && !w_load) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_idx <= '0;
                        case (t_func'(i_func))
                            FUNC_PLAY: begin
                                r_start      <= i_start_address;
                                r_len        <= i_sample_length;
                                r_req_loop   <= i_loop_length;
                                r_req_prio   <= i_request_priority;
                                r_pick       <= '0;
                                r_pick_valid <= 1'b0;
                                r_best       <= '0;
                                r_state      <= S_PLAY;
                            end
                            FUNC_FILL: begin
                                r_mix_mask <= '0;
                                r_snap     <= r_active;
                                r_first    <= 1'b1;
                                r_state    <= (r_active == '0) ? S_CLEAR : S_FILL;
                            end
                            FUNC_MIX: begin
                                r_lane[0] <= i_lane_word_0;
                                r_lane[1] <= i_lane_word_1;
                                r_lane[2] <= i_lane_word_2;
                                r_lane[3] <= i_lane_word_3;
                                r_acc     <= '0;
                                r_state   <= S_MIX;
                            end
                            default: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_PLAY: begin
                    if (!r_active[r_idx]) begin
                        r_pick       <= r_idx;
                        r_pick_valid <= 1'b1;
                        r_state      <= S_PLAY_WRITE;
                    end else begin
                        if (w_steal) begin
                            r_pick       <= r_idx;
                            r_pick_valid <= 1'b1;
                            r_best       <= r_vprio[r_idx];
                        end
                        if (w_scan_done) begin
                            r_state <= S_PLAY_WRITE;
                        end else begin
                            r_idx <= r_idx + 1'b1;
                        end
                    end
                end
                S_PLAY_WRITE: begin
                    if (w_out_free) begin
                        if (r_pick_valid) begin
                            r_active[r_pick] <= 1'b1;
                            r_pos[r_pick]    <= r_start;
                            r_end[r_pick]    <= alu_sum[END_W-1:0];
                            r_loop[r_pick]   <= r_req_loop;
                            r_vprio[r_pick]  <= r_req_prio;
                        end
                        r_out_valid     <= 1'b1;
                        r_voice         <= VOICE_W'(r_pick);
                        r_valid_voice   <= r_pick_valid;
                        r_fetch_address <= '0;
                        r_copy_not_add  <= 1'b0;
                        r_last          <= 1'b1;
                        r_mixed_word    <= '0;
                        r_state         <= S_IDLE;
                    end
                end
                S_FILL: begin
                    if (r_snap[r_idx]) begin
                        r_acc   <= alu_sum;
                        r_state <= S_FILL_WRAP;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_FILL_WRAP: begin
                    if (w_out_free) begin
                        r_out_valid         <= 1'b1;
                        r_voice             <= VOICE_W'(r_idx);
                        r_valid_voice       <= 1'b1;
                        r_fetch_address     <= r_pos[r_idx];
                        r_copy_not_add      <= r_first;
                        r_last              <= !w_more;
                        r_mixed_word        <= '0;
                        r_pos[r_idx]        <= w_wrap_pos;
                        r_mix_mask[r_idx]   <= 1'b1;
                        r_first             <= 1'b0;
                        if (w_stop) begin
                            r_active[r_idx] <= 1'b0;
                        end
                        if (w_more) begin
                            r_idx   <= r_idx + 1'b1;
                            r_state <= S_FILL;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_CLEAR: begin
                    if (w_out_free) begin
                        r_out_valid     <= 1'b1;
                        r_voice         <= '0;
                        r_valid_voice   <= 1'b0;
                        r_fetch_address <= '0;
                        r_copy_not_add  <= 1'b0;
                        r_last          <= 1'b1;
                        r_mixed_word    <= '0;
                        r_state         <= S_IDLE;
                    end
                end
                S_MIX: begin
                    if (r_mix_mask[r_idx]) begin
                        r_acc <= alu_sum;
                    end
                    if (w_mix_done) begin
                        r_state <= S_MIX_EMIT;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_MIX_EMIT: begin
                    if (w_out_free) begin
                        r_out_valid     <= 1'b1;
                        r_voice         <= '0;
                        r_valid_voice   <= |r_mix_mask;
                        r_fetch_address <= '0;
                        r_copy_not_add  <= 1'b0;
                        r_last          <= 1'b1;
                        r_mixed_word    <= r_acc;
                        r_state         <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    `PVBM_ASSERT_NOW(a_pick_legal, i_clk, i_rst_n, (r_state == S_PLAY_WRITE) && r_pick_valid, !r_active[r_pick] || (r_vprio[r_pick] > r_req_prio), "Play chose a voice that may not be taken.")
    `PVBM_ASSERT_NOW(a_partial_from_fill, i_clk, i_rst_n, r_out_valid && !r_last, r_valid_voice && ((r_state == S_FILL) || (r_state == S_FILL_WRAP)), "A non-final result appeared outside a fill.")
    `PVBM_ASSERT_NEXT(a_fill_clears_mask, i_clk, i_rst_n, i_valid && o_ready && (i_func == FUNC_FILL), r_mix_mask == '0, "Fill did not clear the mix record.")
    `PVBM_ASSERT_NOW(a_mask_in_snapshot, i_clk, i_rst_n, (r_state == S_FILL) || (r_state == S_FILL_WRAP), (r_mix_mask & ~r_snap) == '0, "Mix record holds a voice that was idle at the fill.")

endmodule

`default_nettype wire
